/* src/mtc_pkg.sv */
// ----------------------------------------------------------------------------
// mtc_pkg
// Shared types and constants for the machine timer compare register block.
// ----------------------------------------------------------------------------
`default_nettype none

package mtc_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 64;

  // window is four 32-bit words
  localparam int unsigned WindowBytes = 16;
  localparam int unsigned WordBytes   = 4;
  localparam int unsigned WinIdxW     = $clog2(WindowBytes);
  localparam int unsigned ByteOffW    = $clog2(WordBytes);
  localparam int unsigned WordSelW    = WinIdxW - ByteOffW;

  // item kinds
  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  // access sizes
  localparam logic [1:0] SIZE_WORD = 2'd2;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_RANGE     = 2'd1,
    STAT_MISALIGN  = 2'd2,
    STAT_RSVD      = 2'd3
  } status_t;

  // register word select
  localparam logic [WordSelW-1:0] WSEL_TIME_LO = 2'd0;
  localparam logic [WordSelW-1:0] WSEL_TIME_HI = 2'd1;
  localparam logic [WordSelW-1:0] WSEL_CMP_LO  = 2'd2;
  localparam logic [WordSelW-1:0] WSEL_CMP_HI  = 2'd3;

  // decoded request control, access decoder to register file
  typedef struct packed {
    logic                tick;
    logic                rd;
    logic                wr;
    logic [WordSelW-1:0] wsel;
    status_t             status;
  } access_t;

endpackage

`default_nettype wire

/* src/machine_timer_compare_regs_core.sv */
// ----------------------------------------------------------------------------
// machine_timer_compare_regs_core
// Memory-mapped machine timer: 64-bit time counter and compare value.
// ----------------------------------------------------------------------------
// Each request (tick, read or write) is captured in an input register, decoded
// and applied to the time/compare registers as its result is loaded into the
// output register. One request per clock cycle is sustained while the receiver
// keeps out_tready high; out_tvalid rises when that output register loads, and
// a stalled receiver holds at most two requests before in_tready drops. The
// critical path is the 64-bit increment followed by the 64-bit time >= compare
// check that forms irq. The base address must be written through the cfg channel
// only while idle; the block does not enforce this. The window covers base+0
// time low, +4 time high, +8 compare low, +12 compare high, low two base bits ignored.
`default_nettype none

module machine_timer_compare_regs_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: base address
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  // request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // addr[31:0], wdata[63:32], size[65:64], zero pad
  input  wire logic [1:0]  in_tuser,   // func[1:0]
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // rdata[31:0], irq[32], zero pad
  output logic [1:0]       out_tuser   // status[1:0]
);
  import mtc_pkg::*;

  logic [AddrW-1:0] base_r;

  logic             s1_valid_r;
  logic [1:0]       s1_func_r;
  logic [AddrW-1:0] s1_addr_r;
  logic [DataW-1:0] s1_wdata_r;
  logic [1:0]       s1_size_r;

  logic             out_valid_r;
  status_t          out_status_r;
  logic [DataW-1:0] out_rdata_r;
  logic             out_irq_r;

  logic             out_load;
  logic             in_acc;
  access_t          ctl;
  logic [DataW-1:0] rdata;
  logic             irq_nxt;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (cfg_valid) begin
      base_r <= cfg_data;
    end
  end

  // pipeline flow control
  assign out_load  = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || out_load;
  assign in_acc    = in_tvalid && in_tready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r  <= in_tuser;
      s1_addr_r  <= in_tdata[31:0];
      s1_wdata_r <= in_tdata[63:32];
      s1_size_r  <= in_tdata[65:64];
    end
  end

  mtc_access u_access (
    .func         (s1_func_r),
    .addr         (s1_addr_r),
    .size         (s1_size_r),
    .base_address (base_r),
    .ctl          (ctl)
  );

  mtc_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .commit  (out_load),
    .ctl     (ctl),
    .wdata   (s1_wdata_r),
    .rdata   (rdata),
    .irq_nxt (irq_nxt)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= ctl.status;
      out_rdata_r  <= rdata;
      out_irq_r    <= irq_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_irq_r, out_rdata_r};
  assign out_tuser  = out_status_r;

`ifndef SYNTHESIS
  // a stalled pipeline only when both stages are full
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("in_tready low without a full pipeline");

  // failed accesses never return read data
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != STAT_OK)) |-> (out_rdata_r == '0))
    else $error("read data on a failed access");

  // decoder never produces the reserved status or both read and write
  a_ctl_sane: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> ((ctl.status != STAT_RSVD) && !(ctl.rd && ctl.wr)))
    else $error("bad decoded access");

  // a decoded access that fails never writes
  a_fail_nowr: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && (ctl.status != STAT_OK)) |-> (!ctl.wr && !ctl.rd))
    else $error("failed access enabled a register operation");
`endif

endmodule

`default_nettype wire

/* src/mtc_access.sv */
// ----------------------------------------------------------------------------
// mtc_access
// Decodes one request: window range check, alignment check, word select.
// ----------------------------------------------------------------------------
`default_nettype none

module mtc_access (
  input  wire logic [1:0]                func,
  input  wire logic [mtc_pkg::AddrW-1:0] addr,
  input  wire logic [1:0]                size,
  input  wire logic [mtc_pkg::AddrW-1:0] base_address,
  output mtc_pkg::access_t               ctl
);
  import mtc_pkg::*;

  logic [AddrW-1:0] base_al;
  logic [AddrW:0]   diff;
  logic             in_window;
  logic             aligned;
  logic             is_bus;

  // base low bits are ignored; offset computed with borrow so no wrap
  assign base_al   = {base_address[AddrW-1:ByteOffW], {ByteOffW{1'b0}}};
  assign diff      = {1'b0, addr} - {1'b0, base_al};
  assign in_window = (diff[AddrW:WinIdxW] == '0);
  assign aligned   = (size == SIZE_WORD) && (addr[ByteOffW-1:0] == '0);
  assign is_bus    = (func == FUNC_READ) || (func == FUNC_WRITE);

  always_comb begin
    ctl.tick   = (func == FUNC_TICK);
    ctl.rd     = 1'b0;
    ctl.wr     = 1'b0;
    ctl.wsel   = diff[WinIdxW-1:ByteOffW];
    ctl.status = STAT_OK;
    if (is_bus) begin
      if (!in_window) begin
        ctl.status = STAT_RANGE;
      end else if (!aligned) begin
        ctl.status = STAT_MISALIGN;
      end else begin
        ctl.rd = (func == FUNC_READ);
        ctl.wr = (func == FUNC_WRITE);
      end
    end
  end

endmodule

`default_nettype wire

/* src/mtc_regfile.sv */
// ----------------------------------------------------------------------------
// mtc_regfile
// Time counter and compare registers, read mux and interrupt compare.
// ----------------------------------------------------------------------------
`default_nettype none

module mtc_regfile (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      commit,
  input  wire mtc_pkg::access_t          ctl,
  input  wire logic [mtc_pkg::DataW-1:0] wdata,
  output logic      [mtc_pkg::DataW-1:0] rdata,
  output logic                           irq_nxt
);
  import mtc_pkg::*;

  logic [CountW-1:0] time_r, time_nxt;
  logic [CountW-1:0] cmp_r,  cmp_nxt;

  // next state for the request being committed
  always_comb begin
    time_nxt = time_r;
    cmp_nxt  = cmp_r;
    if (ctl.tick) begin
      time_nxt = time_r + CountW'(1);
    end else if (ctl.wr) begin
      case (ctl.wsel)
        WSEL_TIME_LO: time_nxt = {time_r[CountW-1:DataW], wdata};
        WSEL_TIME_HI: time_nxt = {wdata, time_r[DataW-1:0]};
        WSEL_CMP_LO:  cmp_nxt  = {cmp_r[CountW-1:DataW], wdata};
        WSEL_CMP_HI:  cmp_nxt  = {wdata, cmp_r[DataW-1:0]};
        default:      cmp_nxt  = cmp_r;
      endcase
    end
  end

  // read data, zero unless a successful read
  always_comb begin
    rdata = '0;
    if (ctl.rd) begin
      case (ctl.wsel)
        WSEL_TIME_LO: rdata = time_r[DataW-1:0];
        WSEL_TIME_HI: rdata = time_r[CountW-1:DataW];
        WSEL_CMP_LO:  rdata = cmp_r[DataW-1:0];
        WSEL_CMP_HI:  rdata = cmp_r[CountW-1:DataW];
        default:      rdata = '0;
      endcase
    end
  end

  // interrupt seen after this request's update
  assign irq_nxt = (time_nxt >= cmp_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
      cmp_r  <= '1;
    end else if (commit) begin
      time_r <= time_nxt;
      cmp_r  <= cmp_nxt;
    end
  end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the machine timer compare register block.
// ----------------------------------------------------------------------------
// A tracker class keeps its own copy of time, compare and base, and predicts
// status, read data and irq for every request accepted on the input stream.
// Results are checked in order as they leave the output stream. A short
// directed sequence runs first at the reset base. Five random phases follow,
// each under its own base address, sent in bursts with gaps in all but one. The
// receiver stalls on a rotating pattern and holds off once for a long stretch.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mtc_pkg::*;

  localparam logic [1:0]  SIZE_BYTE = 2'd0;
  localparam logic [1:0]  SIZE_HALF = 2'd1;
  localparam logic [1:0]  SIZE_RSVD = 2'd3;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_TAIL = 8;
  localparam int unsigned PHASE_ITEMS = 170;
  localparam longint unsigned LIMIT_NS = 2_000_000;

  typedef struct {
    status_t     status;
    logic [31:0] rdata;
    logic        irq;
  } timer_result_t;

  // Tracks timer state and the results still owed by the block
  class timer_result_tracker;
    logic [63:0]   time_q;
    logic [63:0]   cmp_q;
    logic [31:0]   base_q;
    timer_result_t due_results[$];
    int unsigned   errors;

    function new();
      time_q = '0;
      cmp_q  = '1;
      base_q = '0;
      errors = 0;
    endfunction

    function void set_base(logic [31:0] value);
      base_q = value;
    endfunction

    // Apply one accepted request and queue the result it should give
    function void note_request(func_t kind, logic [31:0] addr, logic [31:0] wdata,
                               logic [1:0] size);
      timer_result_t       r;
      logic [32:0]         win_lo;
      logic [32:0]         win_hi;
      logic [31:0]         offset;
      logic [WordSelW-1:0] wsel;
      r.status = STAT_OK;
      r.rdata  = '0;
      win_lo   = {1'b0, base_q[31:2], 2'b00};
      win_hi   = win_lo + WindowBytes;
      offset   = addr - win_lo[31:0];
      wsel     = offset[WinIdxW-1:ByteOffW];
      case (kind)
        FUNC_TICK: time_q = time_q + 64'd1;
        FUNC_READ, FUNC_WRITE: begin
          // range check comes before alignment; no wrap at the window end
          if ({1'b0, addr} < win_lo || {1'b0, addr} >= win_hi) begin
            r.status = STAT_RANGE;
          end else if (size != SIZE_WORD || addr[ByteOffW-1:0] != '0) begin
            r.status = STAT_MISALIGN;
          end else if (kind == FUNC_READ) begin
            case (wsel)
              WSEL_TIME_LO: r.rdata = time_q[31:0];
              WSEL_TIME_HI: r.rdata = time_q[63:32];
              WSEL_CMP_LO:  r.rdata = cmp_q[31:0];
              default:      r.rdata = cmp_q[63:32];
            endcase
          end else begin
            case (wsel)
              WSEL_TIME_LO: time_q[31:0]  = wdata;
              WSEL_TIME_HI: time_q[63:32] = wdata;
              WSEL_CMP_LO:  cmp_q[31:0]   = wdata;
              default:      cmp_q[63:32]  = wdata;
            endcase
          end
        end
        default: ;
      endcase
      r.irq = (time_q >= cmp_q);
      due_results.push_back(r);
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // Compare one result from the block against the oldest prediction
    task check_result(status_t status, logic [31:0] rdata, logic irq);
      timer_result_t want;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result with no request outstanding (status %0d)",
                                  status));
      end else begin
        want = due_results.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status, want.status));
        if (rdata !== want.rdata)
          report_mismatch($sformatf("rdata %h, want %h", rdata, want.rdata));
        if (irq !== want.irq)
          report_mismatch($sformatf("irq %b, want %b", irq, want.irq));
      end
    endtask

    task check_empty();
      if (due_results.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", due_results.size()));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;   // addr[31:0], wdata[63:32], size[65:64], zero pad
  logic [1:0]  in_tuser;   // func[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // rdata[31:0], irq[32], zero pad
  logic [1:0]  out_tuser;  // status[1:0]

  timer_result_tracker tracker;
  bit                  hold_req;

  machine_timer_compare_regs_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #(LIMIT_NS);
    $display("machine_timer_compare_regs_core regression: fail");
    $finish;
  end

  // request and result monitor; requests are noted first
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      tracker.note_request(func_t'(in_tuser), in_tdata[31:0], in_tdata[63:32],
                           in_tdata[65:64]);
    if (rst_n && out_tvalid && out_tready)
      tracker.check_result(status_t'(out_tuser), out_tdata[31:0], out_tdata[32]);
  end

  // Receiver: stall pattern re-chosen at random periodically, plus one long hold-off
  initial begin
    int unsigned ready_mode;
    int unsigned cycle;
    out_tready = 1'b0;
    ready_mode = 0;
    cycle = 0;
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle % 64 == 0) ready_mode = $urandom_range(0, 3);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        case (ready_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= $urandom_range(0, 1);
          2:       out_tready <= (cycle % 4 != 3);
          default: out_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  function automatic logic [31:0] word_addr(logic [31:0] base, logic [WordSelW-1:0] wsel);
    return {base[31:2], 2'b00} + WordBytes * wsel;
  endfunction

  // Offer one request and wait until the block takes it
  task automatic push_request(input func_t kind, input logic [31:0] addr,
                              input logic [31:0] wdata, input logic [1:0] size);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {6'd0, size, wdata, addr};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    if (cycles != 0) begin
      in_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Stop sending and wait for every owed result
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.due_results.size() != 0);
  endtask

  task automatic write_base(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.set_base(value);
  endtask

  // Random request: mostly legal window accesses, the rest noise
  task automatic pick_request(output func_t kind, output logic [31:0] addr,
                              output logic [31:0] wdata, output logic [1:0] size);
    int unsigned roll;
    logic [31:0] win;
    logic [31:0] offset;
    win  = {tracker.base_q[31:2], 2'b00};
    roll = $urandom_range(0, 99);
    if (roll < 35)      kind = FUNC_TICK;
    else if (roll < 65) kind = FUNC_READ;
    else if (roll < 95) kind = FUNC_WRITE;
    else                kind = FUNC_NONE;
    addr  = $urandom;
    wdata = $urandom;
    size  = 2'($urandom_range(0, 3));
    if (kind == FUNC_READ || kind == FUNC_WRITE) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        addr = word_addr(win, WordSelW'($urandom_range(0, 3)));
        size = SIZE_WORD;
      end else if (roll < 85) begin
        addr = win + $urandom_range(0, WindowBytes - 1);
      end else if (roll < 93) begin
        // just outside either end of the window
        addr = $urandom_range(0, 1) ? win - $urandom_range(1, 8)
                                    : win + WindowBytes + $urandom_range(0, 7);
        size = SIZE_WORD;
      end
    end
    // keep compare near time so irq moves both ways
    if (kind == FUNC_WRITE) begin
      offset = addr - win;
      roll = $urandom_range(0, 99);
      if (roll < 50)
        wdata = offset[2] ? tracker.time_q[63:32]
                          : tracker.time_q[31:0] + $urandom_range(0, 8) - 4;
      else if (roll < 60) wdata = '0;
      else if (roll < 70) wdata = '1;
    end
  endtask

  task automatic run_phase(input int unsigned count, input bit gappy, input bit with_hold);
    func_t       kind;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic [1:0]  size;
    int unsigned left;
    int unsigned burst;
    left = count;
    if (with_hold) hold_req = 1'b1;
    while (left != 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) begin
        pick_request(kind, addr, wdata, size);
        push_request(kind, addr, wdata, size);
      end
      left -= burst;
      if (gappy && left != 0) idle_sender($urandom_range(0, 6));
    end
  endtask

  // Main sequence
  initial begin
    logic [31:0] base;
    tracker    = new();
    hold_req   = 1'b0;
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = FUNC_TICK;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset values, wrap, irq edges, every check, at reset base
    push_request(FUNC_READ,  word_addr(0, WSEL_TIME_LO), '0, SIZE_WORD);
    push_request(FUNC_READ,  word_addr(0, WSEL_CMP_LO),  '0, SIZE_WORD);
    push_request(FUNC_READ,  word_addr(0, WSEL_CMP_HI),  '0, SIZE_WORD);
    push_request(FUNC_TICK,  '1, '1, SIZE_RSVD);
    push_request(FUNC_READ,  word_addr(0, WSEL_TIME_LO), '0, SIZE_WORD);
    push_request(FUNC_WRITE, word_addr(0, WSEL_TIME_HI), '1, SIZE_WORD);
    push_request(FUNC_WRITE, word_addr(0, WSEL_TIME_LO), '1, SIZE_WORD);
    push_request(FUNC_READ,  word_addr(0, WSEL_TIME_HI), '0, SIZE_WORD);
    push_request(FUNC_TICK,  '0, '0, SIZE_WORD);
    push_request(FUNC_WRITE, word_addr(0, WSEL_CMP_HI),  '0, SIZE_WORD);
    push_request(FUNC_WRITE, word_addr(0, WSEL_CMP_LO),  32'd2, SIZE_WORD);
    push_request(FUNC_TICK,  '0, '0, SIZE_WORD);
    push_request(FUNC_TICK,  '0, '0, SIZE_WORD);
    push_request(FUNC_TICK,  '0, '0, SIZE_WORD);
    push_request(FUNC_READ,  32'd2, '0, SIZE_WORD);
    push_request(FUNC_READ,  word_addr(0, WSEL_TIME_LO), '0, SIZE_BYTE);
    push_request(FUNC_READ,  word_addr(0, WSEL_TIME_LO), '0, SIZE_HALF);
    push_request(FUNC_WRITE, word_addr(0, WSEL_CMP_LO),  '0, SIZE_RSVD);
    push_request(FUNC_WRITE, 32'd6, '0, SIZE_WORD);
    push_request(FUNC_WRITE, WindowBytes, '0, SIZE_WORD);
    push_request(FUNC_READ,  32'hFFFF_FFFC, '0, SIZE_WORD);
    push_request(FUNC_NONE,  word_addr(0, WSEL_CMP_LO), '0, SIZE_WORD);
    push_request(FUNC_READ,  word_addr(0, WSEL_CMP_LO),  '0, SIZE_WORD);
    push_request(FUNC_READ,  word_addr(0, WSEL_CMP_HI),  '0, SIZE_WORD);

    // random phases, each under a new base written while idle
    wait_drained();
    write_base(32'h0000_0000);
    run_phase(PHASE_ITEMS, 1'b1, 1'b0);

    wait_drained();
    write_base(32'hFFFF_FFF0);
    run_phase(PHASE_ITEMS, 1'b1, 1'b0);

    // unaligned base, no sender gaps, long receiver hold-off
    wait_drained();
    base = $urandom_range(0, 32'hFFFF_FFEF) | 32'd1;
    write_base(base);
    run_phase(PHASE_ITEMS, 1'b0, 1'b1);

    wait_drained();
    base = $urandom & 32'hFFFF_FFF0;
    write_base(base);
    run_phase(PHASE_ITEMS, 1'b1, 1'b0);

    wait_drained();
    base = $urandom_range(0, 32'hFFFF_FFF0);
    write_base(base);
    run_phase(PHASE_ITEMS, 1'b1, 1'b0);

    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    tracker.check_empty();
    if (tracker.errors == 0)
      $display("machine_timer_compare_regs_core regression: pass");
    else
      $display("machine_timer_compare_regs_core regression: fail");
    $finish;
  end

endmodule
